[hw/rtl/clr_pkg.sv]
// shared types and constants for the clipped line rasteriser
package clr_pkg;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_X_LOW  = 2'd0,
      CSR_WINDOW_X_HIGH = 2'd1,
      CSR_WINDOW_Y_LOW  = 2'd2,
      CSR_WINDOW_Y_HIGH = 2'd3
   } csr_index_type;

   localparam int COLOR_WIDTH = 3;

   localparam longint WINDOW_LOW_RESET  = -249;
   localparam longint WINDOW_HIGH_RESET = 250;

endpackage

[hw/rtl/clipped_line_rasterizer.sv]
// top level of the clipped line rasteriser: request register, line stepper, response register
//
// Bresenham line rasteriser with window clipping. A start request loads two endpoints and a
// colour and returns the first pixel; each step request returns the next pixel, with flags for
// lying inside the window and for being the far endpoint. A step with no line in progress
// returns a response with active low and all other fields zero. The block takes one request
// per cycle while the response side does not stall, and returns one response for each via the
// request and response registers, with the combinational update of the current pixel and the
// decision term in the stepping stage setting that rate. The request and response registers let
// a new request enter while a finished response waits to be taken. The user must write window
// registers through the csr port only while no request is in flight; nothing enforces it.
module clipped_line_rasterizer #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic signed [COORD_WIDTH-1:0]          req_start_x,
   input  logic signed [COORD_WIDTH-1:0]          req_start_y,
   input  logic signed [COORD_WIDTH-1:0]          req_end_x,
   input  logic signed [COORD_WIDTH-1:0]          req_end_y,
   input  logic [clr_pkg::COLOR_WIDTH-1:0]        req_color_index,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_active,
   output logic signed [COORD_WIDTH-1:0]          rsp_pixel_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_pixel_y,
   output logic                                   rsp_visible,
   output logic                                   rsp_last_pixel,
   output logic [clr_pkg::COLOR_WIDTH-1:0]        rsp_pixel_color,
   // configuration
   input  logic                                   csr_write_enable,
   input  logic [clr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_write_data
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int EW = COORD_WIDTH + 4;
   localparam longint CMIN = -(64'sd1 <<< (COORD_WIDTH - 1));
   localparam longint CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam longint LOW_RST  = (clr_pkg::WINDOW_LOW_RESET < CMIN) ?
                                 CMIN : clr_pkg::WINDOW_LOW_RESET;
   localparam longint HIGH_RST = (clr_pkg::WINDOW_HIGH_RESET > CMAX) ?
                                 CMAX : clr_pkg::WINDOW_HIGH_RESET;
   localparam logic signed [COORD_WIDTH-1:0] WIN_LOW_RESET  = COORD_WIDTH'(LOW_RST);
   localparam logic signed [COORD_WIDTH-1:0] WIN_HIGH_RESET = COORD_WIDTH'(HIGH_RST);

   // window registers
   logic signed [COORD_WIDTH-1:0] win_x_low_ff, win_x_high_ff, win_y_low_ff, win_y_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_low_ff  <= WIN_LOW_RESET;
         win_x_high_ff <= WIN_HIGH_RESET;
         win_y_low_ff  <= WIN_LOW_RESET;
         win_y_high_ff <= WIN_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (clr_pkg::csr_index_type'(csr_index))
            clr_pkg::CSR_WINDOW_X_LOW:  win_x_low_ff  <= csr_write_data;
            clr_pkg::CSR_WINDOW_X_HIGH: win_x_high_ff <= csr_write_data;
            clr_pkg::CSR_WINDOW_Y_LOW:  win_y_low_ff  <= csr_write_data;
            clr_pkg::CSR_WINDOW_Y_HIGH: win_y_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request register
   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic signed [COORD_WIDTH-1:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;
   logic [clr_pkg::COLOR_WIDTH-1:0] in_color_ff;
   logic                          out_valid_ff;
   logic                          advance;
   logic                          req_accept;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= req_operation;
         in_sx_ff    <= req_start_x;
         in_sy_ff    <= req_start_y;
         in_ex_ff    <= req_end_x;
         in_ey_ff    <= req_end_y;
         in_color_ff <= req_color_index;
      end
   end

   // line state
   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff, tgt_x_ff, tgt_y_ff;
   logic [DW-1:0]                 dmaj_ff, dmin_ff;
   logic signed [EW-1:0]          decision_ff;
   logic                          x_major_ff, minor_up_ff, busy_ff;
   logic [clr_pkg::COLOR_WIDTH-1:0] color_ff;

   logic signed [COORD_WIDTH-1:0] cur_x_in, cur_y_in, tgt_x_in, tgt_y_in;
   logic [DW-1:0]                 dmaj_in, dmin_in;
   logic signed [EW-1:0]          decision_in;
   logic                          x_major_in, minor_up_in, busy_in;
   logic [clr_pkg::COLOR_WIDTH-1:0] color_in;
   logic                          active_in, last_in;

   // start path
   logic signed [DW-1:0] diff_x, diff_y;
   logic [DW-1:0]        abs_x, abs_y, smaj, smin;
   logic                 s_x_major, s_swap;
   logic signed [COORD_WIDTH-1:0] s_cx, s_cy, s_tx, s_ty;
   // step path
   logic                 minor_step;
   logic signed [COORD_WIDTH-1:0] minor_inc, major_x, major_y, minor_x, minor_y;
   logic signed [EW-1:0] twice_min, twice_maj;

   always_comb begin
      diff_x    = DW'(in_sx_ff) - DW'(in_ex_ff);
      diff_y    = DW'(in_sy_ff) - DW'(in_ey_ff);
      abs_x     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      abs_y     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
      s_x_major = abs_x >= abs_y;
      s_swap    = s_x_major ? !(in_sx_ff < in_ex_ff) : !(in_sy_ff < in_ey_ff);
      s_cx      = s_swap ? in_ex_ff : in_sx_ff;
      s_cy      = s_swap ? in_ey_ff : in_sy_ff;
      s_tx      = s_swap ? in_sx_ff : in_ex_ff;
      s_ty      = s_swap ? in_sy_ff : in_ey_ff;
      smaj      = s_x_major ? abs_x : abs_y;
      smin      = s_x_major ? abs_y : abs_x;

      minor_step = !decision_ff[EW-1];
      minor_inc  = minor_up_ff ? COORD_WIDTH'(1) : {COORD_WIDTH{1'b1}};
      major_x    = cur_x_ff + COORD_WIDTH'(1);
      major_y    = cur_y_ff + COORD_WIDTH'(1);
      minor_x    = minor_step ? cur_x_ff + minor_inc : cur_x_ff;
      minor_y    = minor_step ? cur_y_ff + minor_inc : cur_y_ff;
      twice_min  = {2'b00, dmin_ff, 1'b0};
      twice_maj  = {2'b00, dmaj_ff, 1'b0};

      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      tgt_x_in    = tgt_x_ff;
      tgt_y_in    = tgt_y_ff;
      dmaj_in     = dmaj_ff;
      dmin_in     = dmin_ff;
      decision_in = decision_ff;
      x_major_in  = x_major_ff;
      minor_up_in = minor_up_ff;
      busy_in     = busy_ff;
      color_in    = color_ff;
      active_in   = 1'b0;
      last_in     = 1'b0;

      case (clr_pkg::op_type'(in_op_ff))
         clr_pkg::OP_START: begin
            active_in = 1'b1;
            color_in  = in_color_ff;
            if (abs_x == '0 && abs_y == '0) begin
               cur_x_in = in_sx_ff;
               cur_y_in = in_sy_ff;
               tgt_x_in = in_sx_ff;
               tgt_y_in = in_sy_ff;
               busy_in  = 1'b0;
               last_in  = 1'b1;
            end else begin
               cur_x_in    = s_cx;
               cur_y_in    = s_cy;
               tgt_x_in    = s_tx;
               tgt_y_in    = s_ty;
               x_major_in  = s_x_major;
               minor_up_in = s_x_major ? (s_ty > s_cy) : (s_tx > s_cx);
               dmaj_in     = smaj;
               dmin_in     = smin;
               decision_in = {2'b00, smin, 1'b0} - {3'b000, smaj};
               busy_in     = 1'b1;
            end
         end
         clr_pkg::OP_STEP: begin
            if (busy_ff) begin
               active_in   = 1'b1;
               cur_x_in    = x_major_ff ? major_x : minor_x;
               cur_y_in    = x_major_ff ? minor_y : major_y;
               decision_in = decision_ff + twice_min - (minor_step ? twice_maj : '0);
               last_in     = (cur_x_in == tgt_x_ff) && (cur_y_in == tgt_y_ff);
               busy_in     = !last_in;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         tgt_x_ff    <= '0;
         tgt_y_ff    <= '0;
         dmaj_ff     <= '0;
         dmin_ff     <= '0;
         decision_ff <= '0;
         x_major_ff  <= 1'b0;
         minor_up_ff <= 1'b0;
         busy_ff     <= 1'b0;
         color_ff    <= '0;
      end else if (advance) begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         tgt_x_ff    <= tgt_x_in;
         tgt_y_ff    <= tgt_y_in;
         dmaj_ff     <= dmaj_in;
         dmin_ff     <= dmin_in;
         decision_ff <= decision_in;
         x_major_ff  <= x_major_in;
         minor_up_ff <= minor_up_in;
         busy_ff     <= busy_in;
         color_ff    <= color_in;
      end
   end

   // response register
   logic                            out_active_ff, out_visible_ff, out_last_ff;
   logic signed [COORD_WIDTH-1:0]   out_x_ff, out_y_ff;
   logic [clr_pkg::COLOR_WIDTH-1:0] out_color_ff;
   logic                            visible_in;

   assign visible_in = cur_x_in >= win_x_low_ff && cur_x_in <= win_x_high_ff &&
                       cur_y_in >= win_y_low_ff && cur_y_in <= win_y_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_active_ff  <= active_in;
         out_x_ff       <= active_in ? cur_x_in : '0;
         out_y_ff       <= active_in ? cur_y_in : '0;
         out_visible_ff <= active_in && visible_in;
         out_last_ff    <= last_in;
         out_color_ff   <= active_in ? color_in : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_active      = out_active_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_visible     = out_visible_ff;
   assign rsp_last_pixel  = out_last_ff;
   assign rsp_pixel_color = out_color_ff;

endmodule

[hw/rtl/clr_checker.sv]
// port-level assertions for the clipped line rasteriser, bound to the top level
module clr_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_active,
   input logic signed [COORD_WIDTH-1:0]       rsp_pixel_x,
   input logic signed [COORD_WIDTH-1:0]       rsp_pixel_y,
   input logic                                rsp_visible,
   input logic                                rsp_last_pixel,
   input logic [clr_pkg::COLOR_WIDTH-1:0]     rsp_pixel_color
);

   // an idle response carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
         !rsp_visible && !rsp_last_pixel && rsp_pixel_color == '0)
      else $error("idle response with non-zero fields");

   // the request side only stalls behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no held response");

   // nothing is returned straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_active) && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_visible) && $stable(rsp_last_pixel) &&
         $stable(rsp_pixel_color))
      else $error("stalled response changed");

endmodule

bind clipped_line_rasterizer clr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_clr_checker (.*);
